// ===== rtl/csd_pkg.sv =====
// Package for the CAN signal decoder: widths, register indexes, status codes,
// table entry types. No dependencies.
package csd_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 29;
    localparam int unsigned ID_W        = 29;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;

    localparam logic [28:0] TRIGGER_RST = 29'h100;
    localparam logic [7:0]  LIMIT_RST   = 8'd8;

    localparam logic [1:0] ST_CHANGED   = 2'd0;
    localparam logic [1:0] ST_UNCHANGED = 2'd1;
    localparam logic [1:0] ST_MISSING   = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] can_id;
        logic [1:0]      byte_count;
        logic [2:0]      hi_idx;
        logic [2:0]      lo_idx;
        logic            checked;
        logic signed [15:0] mul;
        logic signed [15:0] div;
        logic signed [15:0] off;
    } t_entry;

    // divider request/response between the walker and the divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic signed [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/csd_div.sv =====
// Signed 32/16 restoring divider, one quotient bit per cycle, truncates
// toward zero. Depends on csd_pkg.
module csd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  csd_pkg::t_div_req i_req,
    output csd_pkg::t_div_rsp o_rsp
);
    import csd_pkg::*;

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_quo;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic        r_neg;
    logic        r_done;
    logic [16:0] w_trial;
    logic [16:0] w_shift;

    assign w_shift = {r_rem[15:0], r_quo[31]};
    assign w_trial = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num[31] ? 32'(-i_req.num) : i_req.num;
            r_den <= i_req.den[15] ? 16'(-i_req.den) : i_req.den;
            r_neg <= i_req.num[31] ^ i_req.den[15];
            r_rem <= '0;
        end else if (r_busy) begin
            if (!w_trial[16]) begin
                r_rem <= w_trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= w_shift;
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? 32'(-r_quo) : r_quo;

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0) else $error("divider count ran out");
`endif

endmodule

// ===== rtl/can_signal_decoder.sv =====
// CAN signal decoder: one frame walks every active table slot in order.
// A matching slot with its bytes present is read from memory, multiplied,
// divided serially and its shown value read-modify-written; a non-matching
// slot is only read and compared. One word at a time: none is taken until
// the walk ends and its last result is handed on. Reset (synchronous, active low)
// resets config, control state and shown flags only, not tables or data.
module can_signal_decoder #(
    parameter int unsigned ENTRIES = csd_pkg::ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [csd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_mode,
    input  logic [28:0]                    i_can_id,
    input  logic [3:0]                     i_frame_length,
    input  logic [63:0]                    i_payload,
    input  logic [3:0]                     i_entry_index,
    input  logic [1:0]                     i_byte_count,
    input  logic [2:0]                     i_high_byte_index,
    input  logic [2:0]                     i_low_byte_index,
    input  logic signed [15:0]             i_scale_multiplier,
    input  logic signed [15:0]             i_scale_divisor,
    input  logic signed [15:0]             i_value_offset,
    input  logic                           i_range_checked,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [3:0]                     o_slot,
    output logic signed [31:0]             o_value,
    output logic [1:0]                     o_status,
    output logic                           o_shift_light,
    output logic                           o_last
);
    import csd_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_POST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    // configuration
    logic [4:0]  r_active;
    logic [28:0] r_trigger;
    logic [7:0]  r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_trigger <= TRIGGER_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACTIVE:  r_active  <= i_cfg_data[4:0];
                REG_TRIGGER: r_trigger <= i_cfg_data[28:0];
                REG_LIMIT:   r_limit   <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // memories
    t_entry             m_tbl [ENTRIES];
    logic signed [31:0] m_shown [ENTRIES];
    logic [ENTRIES-1:0] r_flag;
    t_entry             r_ent;
    logic signed [31:0] r_shown_rd;

    logic [2:0]  r_state;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_limit_n;
    logic [28:0] r_id;
    logic [3:0]  r_flen;
    logic [63:0] r_pay;
    logic signed [31:0] r_prod;
    logic signed [32:0] r_v;
    logic        r_any;
    logic        r_pend;
    logic [3:0]  r_pslot;
    logic signed [31:0] r_pval;
    logic [1:0]  r_pstat;
    logic [1:0]  r_hstat;
    logic        r_plight;
    logic        r_ovalid;
    logic [3:0]  r_oslot;
    logic signed [31:0] r_oval;
    logic [1:0]  r_ostat;
    logic        r_olight;
    logic        r_olast;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    logic        w_accept;
    logic        w_load_ok;
    logic [3:0]  w_eflen;
    logic [7:0]  w_bhi;
    logic [7:0]  w_blo;
    logic        w_ok;
    logic        w_slot_write;
    logic        w_out_free;
    logic        w_emit_mid;
    logic        w_emit_end;
    logic [AW-1:0] w_ai;
    logic [AW-1:0] w_li;

    assign w_ai     = r_idx[AW-1:0];
    assign w_li     = AW'(i_entry_index);
    assign o_ready  = (r_state == S_IDLE) && !r_pend;
    assign w_accept = i_valid && o_ready;
    assign w_load_ok = w_accept && i_mode && ({2'b0, i_entry_index} < 6'(ENTRIES));
    assign w_eflen  = (r_flen > 4'd8) ? 4'd8 : r_flen;
    assign w_bhi    = r_pay[{r_ent.hi_idx, 3'b000} +: 8];
    assign w_blo    = r_pay[{r_ent.lo_idx, 3'b000} +: 8];
    assign w_ok     = (r_ent.byte_count == 2'd1 && {1'b0, r_ent.lo_idx} < w_eflen) ||
                      (r_ent.byte_count == 2'd2 && {1'b0, r_ent.lo_idx} < w_eflen &&
                       {1'b0, r_ent.hi_idx} < w_eflen);
    assign w_out_free = !r_ovalid || i_ready;
    assign w_emit_mid = (r_state == S_OUT) && r_pend && w_out_free;
    assign w_emit_end = (r_state == S_IDLE) && r_pend && w_out_free;

    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            m_tbl[w_li] <= '{i_can_id, i_byte_count, i_high_byte_index,
                i_low_byte_index, i_range_checked, i_scale_multiplier, i_scale_divisor,
                i_value_offset};
        end
        if (r_state == S_READ) begin
            r_ent      <= m_tbl[w_ai];
            r_shown_rd <= m_shown[w_ai];
        end
        if (w_slot_write) begin
            m_shown[w_ai] <= r_v[31:0];
        end
    end

    assign w_slot_write = (r_state == S_POST) && !(r_ent.checked &&
        (r_v < 0 || r_v > $signed({25'd0, r_limit}))) &&
        !(r_flag[w_ai] && r_shown_rd == r_v[31:0]);

    assign w_dreq.start = (r_state == S_MUL);
    assign w_dreq.num   = r_prod;
    assign w_dreq.den   = (r_ent.div == 16'sd0) ? 16'sd1 : r_ent.div;

    csd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_flag   <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_any    <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (w_emit_mid || w_emit_end) begin
                r_ovalid <= 1'b1;
                r_oslot  <= r_pslot;
                r_oval   <= r_pval;
                r_ostat  <= r_hstat;
                r_olight <= r_plight;
                r_olast  <= w_emit_end;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_load_ok) r_flag[w_li] <= 1'b0;
            // pending result goes out once the next match (or end) decides last
            case (r_state)
                S_IDLE: begin
                    if (w_accept && !i_mode) begin
                        r_id   <= i_can_id;
                        r_flen <= i_frame_length;
                        r_pay  <= i_payload;
                        r_idx  <= '0;
                        r_any  <= 1'b0;
                        r_limit_n <= ({1'b0, r_active} > 6'(ENTRIES)) ? CW'(ENTRIES)
                            : CW'(r_active);
                        r_state <= S_READ;
                    end
                    if (w_emit_end) r_pend <= 1'b0;
                end
                S_READ: begin
                    if (r_idx >= r_limit_n) r_state <= S_IDLE;
                    else r_state <= S_TEST;
                end
                S_TEST: begin
                    if (r_ent.can_id != r_id) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_READ;
                    end else if (!w_ok) begin
                        r_v     <= '0;
                        r_state <= S_OUT;
                        r_pstat <= ST_MISSING;
                    end else begin
                        r_pstat <= ST_CHANGED;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: if (w_drsp.done) begin
                    r_v     <= 33'(w_drsp.quo) + 33'(r_ent.off);
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (r_ent.checked && (r_v < 0 || r_v > $signed({25'd0, r_limit}))) begin
                        r_pstat <= ST_RANGE;
                        r_v     <= '0;
                    end else if (r_flag[w_ai] && r_shown_rd == r_v[31:0]) begin
                        r_pstat <= ST_UNCHANGED;
                    end else begin
                        r_pstat <= ST_CHANGED;
                        r_flag[w_ai] <= 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // previous match is not last; send it before holding this one
                    if (!r_pend || w_out_free) begin
                        r_pend   <= 1'b1;
                        r_pslot  <= 4'(r_idx);
                        r_pval   <= (r_pstat[1]) ? 32'sd0 : r_v[31:0];
                        r_hstat  <= r_pstat;
                        r_plight <= !r_pstat[1] && (r_id == r_trigger);
                        r_any    <= 1'b1;
                        r_idx    <= r_idx + CW'(1);
                        r_state  <= S_READ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TEST)
            r_prod <= 32'(signed'({1'b0, (r_ent.byte_count == 2'd2) ? {w_bhi, w_blo}
                : {8'd0, w_blo}})) * 32'((r_ent.mul == 16'sd0) ? 16'sd1 : r_ent.mul);
    end

    assign o_valid       = r_ovalid;
    assign o_slot        = r_oslot;
    assign o_value       = r_oval;
    assign o_status      = r_ostat;
    assign o_shift_light = r_olight;
    assign o_last        = r_olast;

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("word dropped");
    a_light_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_shift_light |-> !o_status[1]) else $error("light on bad status");
    a_pend_any: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend && r_state != S_IDLE |-> r_any) else $error("pending without match");
`endif

endmodule

// ===== dv/csd_checker.sv =====
// Checker for the CAN signal decoder: watches the config port and both
// channels, predicts each frame's results and compares them. Needs csd_pkg.
module csd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [csd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [csd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_valid,
    input  logic                           i_ready_in,
    input  logic                           i_mode,
    input  logic [28:0]                    i_can_id,
    input  logic [3:0]                     i_frame_length,
    input  logic [63:0]                    i_payload,
    input  logic [3:0]                     i_entry_index,
    input  logic [1:0]                     i_byte_count,
    input  logic [2:0]                     i_high_byte_index,
    input  logic [2:0]                     i_low_byte_index,
    input  logic signed [15:0]             i_scale_multiplier,
    input  logic signed [15:0]             i_scale_divisor,
    input  logic signed [15:0]             i_value_offset,
    input  logic                           i_range_checked,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [3:0]                     i_slot,
    input  logic signed [31:0]             i_value,
    input  logic [1:0]                     i_status,
    input  logic                           i_shift_light,
    input  logic                           i_last,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import csd_pkg::*;

    typedef struct packed {
        logic [3:0]         slot;
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               light;
        logic               last;
    } t_signal;

    t_signal            signal_q[$];
    t_entry             map_tbl[16];
    logic signed [31:0] shown_val[16];
    logic               shown_ok[16];
    logic [4:0]         active_cnt;
    logic [28:0]        trig_id;
    logic [7:0]         lim;

    function automatic logic [7:0] byte_at(logic [63:0] pl, logic [2:0] k);
        return pl[k*8 +: 8];
    endfunction

    task automatic decode_frame(logic [28:0] id, logic [3:0] flen, logic [63:0] pl);
        int          n_slots;
        int          first_new;
        logic [15:0] raw;
        logic        ok;
        longint      mul, dv, v;
        t_signal     s;
        n_slots = (active_cnt > 16) ? 16 : active_cnt;
        first_new = signal_q.size();
        for (int i = 0; i < n_slots; i++) begin
            if (map_tbl[i].can_id == id) begin
                ok = 1'b0;
                raw = '0;
                if (map_tbl[i].byte_count == 2'd1) begin
                    if (map_tbl[i].lo_idx < flen) begin
                        raw = {8'd0, byte_at(pl, map_tbl[i].lo_idx)};
                        ok = 1'b1;
                    end
                end else if (map_tbl[i].byte_count == 2'd2) begin
                    if (map_tbl[i].hi_idx < flen && map_tbl[i].lo_idx < flen) begin
                        raw = {byte_at(pl, map_tbl[i].hi_idx), byte_at(pl, map_tbl[i].lo_idx)};
                        ok = 1'b1;
                    end
                end
                s = '0;
                s.slot = i[3:0];
                if (!ok) begin
                    s.status = ST_MISSING;
                end else begin
                    mul = (map_tbl[i].mul == 0) ? 64'sd1 : longint'(map_tbl[i].mul);
                    dv  = (map_tbl[i].div == 0) ? 64'sd1 : longint'(map_tbl[i].div);
                    v = longint'(raw) * mul / dv + longint'(map_tbl[i].off);
                    if (map_tbl[i].checked && (v < 0 || v > longint'(lim))) begin
                        s.status = ST_RANGE;
                    end else begin
                        s.value = v[31:0];
                        s.light = (id == trig_id);
                        if (shown_ok[i] && shown_val[i] == s.value) begin
                            s.status = ST_UNCHANGED;
                        end else begin
                            shown_val[i] = s.value;
                            shown_ok[i] = 1'b1;
                            s.status = ST_CHANGED;
                        end
                    end
                end
                signal_q.push_back(s);
            end
        end
        if (signal_q.size() > first_new) signal_q[signal_q.size()-1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_signal e;
        if (!i_rst_n) begin
            active_cnt = 5'd0;
            trig_id = TRIGGER_RST;
            lim = LIMIT_RST;
            for (int i = 0; i < 16; i++) shown_ok[i] = 1'b0;
            signal_q.delete();
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACTIVE:  active_cnt = i_cfg_data[4:0];
                    REG_TRIGGER: trig_id = i_cfg_data[28:0];
                    REG_LIMIT:   lim = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (signal_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result slot=%0d value=%0d status=%0d",
                                 $realtime, i_slot, i_value, i_status);
                end else begin
                    e = signal_q.pop_front();
                    if (e.slot != i_slot || e.value != i_value || e.status != i_status ||
                        e.light != i_shift_light || e.last != i_last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: mismatch exp slot=%0d value=%0d status=%0d ",
                                      "light=%0d last=%0d, got %0d %0d %0d %0d %0d"},
                                     $realtime, e.slot, e.value, e.status, e.light, e.last,
                                     i_slot, i_value, i_status, i_shift_light, i_last);
                    end
                end
            end
            if (i_valid && i_ready_in) begin
                if (i_mode) begin
                    map_tbl[i_entry_index] = '{can_id: i_can_id, byte_count: i_byte_count,
                        hi_idx: i_high_byte_index, lo_idx: i_low_byte_index,
                        checked: i_range_checked, mul: i_scale_multiplier,
                        div: i_scale_divisor, off: i_value_offset};
                    shown_ok[i_entry_index] = 1'b0;
                end else begin
                    decode_frame(i_can_id, i_frame_length, i_payload);
                end
            end
        end
        o_pending = signal_q.size();
    end
endmodule

// ===== dv/testbench.sv =====
// Top of the CAN signal decoder testbench: clock, reset, config writes and
// word stimulus with random idling. Needs csd_pkg, csd_checker, the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import csd_pkg::*;

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid, o_ready, i_mode;
    logic [28:0]           i_can_id;
    logic [3:0]            i_frame_length, i_entry_index;
    logic [63:0]           i_payload;
    logic [1:0]            i_byte_count;
    logic [2:0]            i_high_byte_index, i_low_byte_index;
    logic signed [15:0]    i_scale_multiplier, i_scale_divisor, i_value_offset;
    logic                  i_range_checked;
    logic                  o_valid, i_ready;
    logic [3:0]            o_slot;
    logic signed [31:0]    o_value;
    logic [1:0]            o_status;
    logic                  o_shift_light, o_last;
    int                    fail_count, pending, result_count;
    int                    tx_gap_pct, rx_idle_pct;
    int                    frames_sent, loads_sent;
    logic [28:0]           id_pool[4];

    can_signal_decoder DUT (.*);

    csd_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_mode, .i_can_id, .i_frame_length,
        .i_payload, .i_entry_index, .i_byte_count, .i_high_byte_index,
        .i_low_byte_index, .i_scale_multiplier, .i_scale_divisor,
        .i_value_offset, .i_range_checked,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_slot(o_slot),
        .i_value(o_value), .i_status(o_status), .i_shift_light(o_shift_light),
        .i_last(o_last), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= rx_idle_pct);

    initial begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic send_word(logic mode, logic [28:0] id, logic [3:0] flen, logic [63:0] pl,
                             logic [3:0] idx, logic [1:0] cnt, logic [2:0] hi, logic [2:0] lo,
                             logic [15:0] mul, logic [15:0] dv, logic [15:0] off,
                             logic chk);
        if ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_mode <= mode;
        i_can_id <= id;
        i_frame_length <= flen;
        i_payload <= pl;
        i_entry_index <= idx;
        i_byte_count <= cnt;
        i_high_byte_index <= hi;
        i_low_byte_index <= lo;
        i_scale_multiplier <= mul;
        i_scale_divisor <= dv;
        i_value_offset <= off;
        i_range_checked <= chk;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        if (mode) loads_sent++; else frames_sent++;
    endtask

    function automatic logic [15:0] pick_scale();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'($urandom_range(1, 20));
            3: return -16'($urandom_range(1, 20));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic load_random(logic [3:0] idx);
        logic [1:0] cnt;
        cnt = ($urandom_range(9) < 8) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
        send_word(1'b1, ($urandom_range(9) == 0) ? 29'($urandom) : id_pool[$urandom_range(3)],
                  4'($urandom), {$urandom, $urandom}, idx, cnt, 3'($urandom), 3'($urandom),
                  pick_scale(), pick_scale(), ($urandom_range(1)) ? 16'($urandom_range(20))
                  : 16'($urandom), 1'($urandom));
    endtask

    task automatic frame_random();
        logic [28:0] id;
        logic [3:0]  flen;
        id = ($urandom_range(9) == 0) ? 29'($urandom) : id_pool[$urandom_range(3)];
        flen = ($urandom_range(2) == 0) ? 4'($urandom) : 4'd8;
        send_word(1'b0, id, flen, {$urandom, $urandom}, 4'($urandom), 2'($urandom),
                  3'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 1'($urandom));
    endtask

    task automatic frame(logic [28:0] id, logic [3:0] flen, logic [63:0] pl);
        send_word(1'b0, id, flen, pl, '0, '0, '0, '0, '0, '0, '0, 1'b0);
    endtask

    task automatic load(logic [3:0] idx, logic [28:0] id, logic [1:0] cnt, logic [2:0] hi,
                        logic [2:0] lo, logic [15:0] mul, logic [15:0] dv, logic [15:0] off,
                        logic chk);
        send_word(1'b1, id, 4'($urandom), {$urandom, $urandom}, idx, cnt, hi, lo,
                  mul, dv, off, chk);
    endtask

    initial begin
        logic [28:0] trig_set[6];
        int          act_set[6];
        int          lim_set[6];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = '0; i_cfg_data = '0;
        i_valid = 1'b0; i_mode = 1'b0; i_can_id = '0; i_frame_length = '0;
        i_payload = '0; i_entry_index = '0; i_byte_count = '0;
        i_high_byte_index = '0; i_low_byte_index = '0;
        i_scale_multiplier = '0; i_scale_divisor = '0; i_value_offset = '0;
        i_range_checked = 1'b0;
        tx_gap_pct = 10; rx_idle_pct = 56;
        frames_sent = 0; loads_sent = 0;
        id_pool[0] = 29'h1FFFFFFF;
        id_pool[1] = 29'h0;
        id_pool[2] = 29'($urandom);
        id_pool[3] = 29'($urandom);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fill every slot first so no frame ever reads an unloaded one
        write_reg(REG_ACTIVE, 29'd16);
        write_reg(REG_TRIGGER, 29'd0);
        write_reg(REG_LIMIT, 29'd8);
        load(4'd0, id_pool[0], 2'd1, 3'd0, 3'd0, 16'd0, 16'd0, 16'd0, 1'b0);
        load(4'd1, id_pool[0], 2'd2, 3'd7, 3'd0, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
        load(4'd2, id_pool[0], 2'd0, 3'd1, 3'd1, 16'd1, 16'd1, 16'd0, 1'b0);
        load(4'd3, id_pool[0], 2'd3, 3'd2, 3'd2, 16'd1, 16'd1, 16'd0, 1'b0);
        load(4'd4, id_pool[0], 2'd1, 3'd3, 3'd3, 16'd1, 16'd1, 16'd0, 1'b1);
        load(4'd5, id_pool[1], 2'd2, 3'd1, 3'd2, 16'h7FFF, 16'h0001, 16'h7FFF, 1'b0);
        load(4'd6, id_pool[1], 2'd2, 3'd7, 3'd6, 16'hFFFF, 16'h0003, 16'h0005, 1'b1);
        for (int i = 7; i < 16; i++) load_random(4'(i));
        frame(id_pool[0], 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
        frame(id_pool[0], 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);   // repeat: unchanged
        frame(id_pool[0], 4'd0, 64'h0123_4567_89AB_CDEF);   // nothing present
        frame(id_pool[0], 4'd15, 64'h0000_0000_0500_0000);  // long frame, in range
        frame(id_pool[1], 4'd8, 64'h0);                      // trigger id 0
        frame(id_pool[1], 4'd7, {$urandom, $urandom});
        frame(id_pool[0], 4'd4, {$urandom, $urandom});
        frame(29'h0ABCDEF ^ id_pool[2], 4'd8, {$urandom, $urandom});
        i_valid <= 1'b0;
        settle();

        act_set  = '{16, 0, 31, 5, 0, 16};
        lim_set  = '{255, 8, 0, 100, 0, 8};
        trig_set = '{id_pool[2], 29'h1FFFFFFF, id_pool[1], id_pool[0], 29'h0, id_pool[3]};
        act_set[4]  = $urandom_range(1, 31);
        lim_set[4]  = $urandom_range(255);
        trig_set[4] = id_pool[$urandom_range(3)];
        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin tx_gap_pct = 10; rx_idle_pct = 56; end
                1: begin tx_gap_pct = 56; rx_idle_pct = 10; end
                default: begin tx_gap_pct = 0; rx_idle_pct = 0; end
            endcase
            write_reg(REG_ACTIVE, 29'(act_set[ph]));
            write_reg(REG_TRIGGER, trig_set[ph]);
            write_reg(REG_LIMIT, 29'(lim_set[ph]));
            for (int k = 0; k < 33; k++) begin
                if ($urandom_range(5) == 0) load_random(4'($urandom));
                else frame_random();
            end
            i_valid <= 1'b0;
            settle();
        end

        $display("Sent %0d frames and %0d table loads, %0d results checked.",
                 frames_sent, loads_sent, result_count);
        $display("Six register settings, three idling profiles on both channels.");
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
